// ===== rtl/cbd_pkg.sv =====
package cbd_pkg;

  localparam int CELL_W     = 16;
  localparam int IDX_W      = 4;
  localparam int VOLT_W     = 16;
  localparam int DIFF_W     = 8;
  localparam int CNT_W      = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [VOLT_W-1:0] ALL_ON_LEVEL  = 16'd3550;
  localparam logic [VOLT_W-1:0] ALL_OFF_LEVEL = 16'd3400;

  localparam logic [DIFF_W-1:0] RST_DIFF_HIGH_NORMAL = 8'd80;
  localparam logic [DIFF_W-1:0] RST_DIFF_LOW_NORMAL  = 8'd50;
  localparam logic [DIFF_W-1:0] RST_DIFF_HIGH_TIGHT  = 8'd50;
  localparam logic [DIFF_W-1:0] RST_DIFF_LOW_TIGHT   = 8'd30;
  localparam logic [VOLT_W-1:0] RST_LOWEST_GATE      = 16'd3400;
  localparam logic [CNT_W-1:0]  RST_COUNT_LIMIT      = 8'd10;
  localparam logic [VOLT_W-1:0] RST_CELL_THRESHOLD   = 16'd3475;
  localparam logic [VOLT_W-1:0] RST_TIGHT_LEVEL      = 16'd3480;

  typedef enum logic [2:0] {
    REG_DIFF_HIGH_NORMAL = 3'd0,
    REG_DIFF_LOW_NORMAL  = 3'd1,
    REG_DIFF_HIGH_TIGHT  = 3'd2,
    REG_DIFF_LOW_TIGHT   = 3'd3,
    REG_LOWEST_GATE      = 3'd4,
    REG_COUNT_LIMIT      = 3'd5,
    REG_CELL_THRESHOLD   = 3'd6,
    REG_TIGHT_LEVEL      = 3'd7
  } reg_idx_t;

  typedef enum logic {
    REQ_SAMPLE   = 1'b0,
    REQ_EVALUATE = 1'b1
  } req_t;

  typedef struct packed {
    logic [DIFF_W-1:0] diff_high_normal;
    logic [DIFF_W-1:0] diff_low_normal;
    logic [DIFF_W-1:0] diff_high_tight;
    logic [DIFF_W-1:0] diff_low_tight;
    logic [VOLT_W-1:0] lowest_gate;
    logic [CNT_W-1:0]  count_limit;
    logic [VOLT_W-1:0] cell_threshold;
    logic [VOLT_W-1:0] tight_level;
  } cfg_t;

  typedef struct packed {
    req_t              req_type;
    logic [IDX_W-1:0]  cell_index;
    logic [VOLT_W-1:0] cell_voltage;
    logic [VOLT_W-1:0] max_cell_voltage;
    logic [VOLT_W-1:0] min_cell_voltage;
    logic              comm_force_off;
    logic              comm_force_on;
    logic              hardware_fault;
    logic              balance_allowed;
    logic              cells_saturated;
  } item_t;

  typedef struct packed {
    logic              balance_enable;
    logic [CELL_W-1:0] cell_mask;
    logic              tight_mode;
  } result_t;

endpackage

// ===== rtl/cbd_ifs.sv =====
interface cbd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  cell_index;
  logic [15:0] cell_voltage;
  logic [15:0] max_cell_voltage;
  logic [15:0] min_cell_voltage;
  logic        comm_force_off;
  logic        comm_force_on;
  logic        hardware_fault;
  logic        balance_allowed;
  logic        cells_saturated;

  modport source (
    output valid, req_type, cell_index, cell_voltage, max_cell_voltage,
           min_cell_voltage, comm_force_off, comm_force_on, hardware_fault,
           balance_allowed, cells_saturated,
    input  ready
  );
  modport sink (
    input  valid, req_type, cell_index, cell_voltage, max_cell_voltage,
           min_cell_voltage, comm_force_off, comm_force_on, hardware_fault,
           balance_allowed, cells_saturated,
    output ready
  );
endinterface

interface cbd_out_if;
  logic        valid;
  logic        ready;
  logic        balance_enable;
  logic [15:0] cell_mask;
  logic        tight_mode;

  modport source (
    output valid, balance_enable, cell_mask, tight_mode,
    input  ready
  );
  modport sink (
    input  valid, balance_enable, cell_mask, tight_mode,
    output ready
  );
endinterface

// ===== rtl/cbd_regs.sv =====
module cbd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cbd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cbd_pkg::APB_DATA_W-1:0]   prdata,
  output cbd_pkg::cfg_t                    cfg
);
  import cbd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_DIFF_HIGH_NORMAL: cfg_nxt.diff_high_normal = pwdata[DIFF_W-1:0];
        REG_DIFF_LOW_NORMAL:  cfg_nxt.diff_low_normal  = pwdata[DIFF_W-1:0];
        REG_DIFF_HIGH_TIGHT:  cfg_nxt.diff_high_tight  = pwdata[DIFF_W-1:0];
        REG_DIFF_LOW_TIGHT:   cfg_nxt.diff_low_tight   = pwdata[DIFF_W-1:0];
        REG_LOWEST_GATE:      cfg_nxt.lowest_gate      = pwdata[VOLT_W-1:0];
        REG_COUNT_LIMIT:      cfg_nxt.count_limit      = pwdata[CNT_W-1:0];
        REG_CELL_THRESHOLD:   cfg_nxt.cell_threshold   = pwdata[VOLT_W-1:0];
        REG_TIGHT_LEVEL:      cfg_nxt.tight_level      = pwdata[VOLT_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DIFF_HIGH_NORMAL: prdata = APB_DATA_W'(cfg_r.diff_high_normal);
      REG_DIFF_LOW_NORMAL:  prdata = APB_DATA_W'(cfg_r.diff_low_normal);
      REG_DIFF_HIGH_TIGHT:  prdata = APB_DATA_W'(cfg_r.diff_high_tight);
      REG_DIFF_LOW_TIGHT:   prdata = APB_DATA_W'(cfg_r.diff_low_tight);
      REG_LOWEST_GATE:      prdata = APB_DATA_W'(cfg_r.lowest_gate);
      REG_COUNT_LIMIT:      prdata = APB_DATA_W'(cfg_r.count_limit);
      REG_CELL_THRESHOLD:   prdata = APB_DATA_W'(cfg_r.cell_threshold);
      REG_TIGHT_LEVEL:      prdata = APB_DATA_W'(cfg_r.tight_level);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diff_high_normal <= RST_DIFF_HIGH_NORMAL;
      cfg_r.diff_low_normal  <= RST_DIFF_LOW_NORMAL;
      cfg_r.diff_high_tight  <= RST_DIFF_HIGH_TIGHT;
      cfg_r.diff_low_tight   <= RST_DIFF_LOW_TIGHT;
      cfg_r.lowest_gate      <= RST_LOWEST_GATE;
      cfg_r.count_limit      <= RST_COUNT_LIMIT;
      cfg_r.cell_threshold   <= RST_CELL_THRESHOLD;
      cfg_r.tight_level      <= RST_TIGHT_LEVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/cbd_core.sv =====
module cbd_core #(
  parameter int NUM_CELLS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  cbd_pkg::item_t   item,
  input  cbd_pkg::cfg_t    cfg,
  output cbd_pkg::result_t result
);
  import cbd_pkg::*;

  localparam logic [CELL_W-1:0] VALID_MASK =
    (NUM_CELLS >= CELL_W) ? {CELL_W{1'b1}} : CELL_W'((32'd1 << NUM_CELLS) - 32'd1);

  logic              enable_r, enable_nxt;
  logic              tight_r, tight_nxt;
  logic [CNT_W-1:0]  tight_cnt_r, tight_cnt_nxt;
  logic [CNT_W-1:0]  on_cnt_r, on_cnt_nxt;
  logic [CNT_W-1:0]  off_cnt_r, off_cnt_nxt;
  logic [CELL_W-1:0] above_r, above_nxt;
  logic [CELL_W-1:0] mask_r, mask_nxt;

  logic [DIFF_W-1:0]    hi, lo;
  logic signed [VOLT_W:0] spread;
  logic                 idx_ok;

  assign spread = $signed({1'b0, item.max_cell_voltage})
                - $signed({1'b0, item.min_cell_voltage});
  assign idx_ok = (32'(item.cell_index) < NUM_CELLS);

  always_comb begin
    enable_nxt    = enable_r;
    tight_nxt     = tight_r;
    tight_cnt_nxt = tight_cnt_r;
    on_cnt_nxt    = on_cnt_r;
    off_cnt_nxt   = off_cnt_r;
    above_nxt     = above_r;
    mask_nxt      = mask_r;
    hi            = cfg.diff_high_normal;
    lo            = cfg.diff_low_normal;

    if (item.req_type == REQ_SAMPLE) begin
      if (idx_ok) begin
        above_nxt[item.cell_index] = (item.cell_voltage > cfg.cell_threshold);
      end
    end else if (item.comm_force_off) begin
      enable_nxt = 1'b0;
    end else if (item.comm_force_on) begin
      enable_nxt = 1'b1;
    end else if (!item.balance_allowed) begin
      enable_nxt = 1'b0;
    end else begin
      if (item.hardware_fault) begin
        enable_nxt = 1'b0;
      end
      // tight-mode debounce
      if (item.min_cell_voltage > cfg.tight_level) begin
        tight_cnt_nxt = tight_cnt_r + 1'b1;
        if (tight_cnt_nxt >= cfg.count_limit) begin
          tight_nxt     = 1'b1;
          tight_cnt_nxt = '0;
        end
      end else begin
        tight_nxt     = 1'b0;
        tight_cnt_nxt = '0;
      end
      hi = tight_nxt ? cfg.diff_high_tight : cfg.diff_high_normal;
      lo = tight_nxt ? cfg.diff_low_tight  : cfg.diff_low_normal;
      // spread hysteresis
      if (spread >= $signed({{(VOLT_W-DIFF_W+1){1'b0}}, hi}) &&
          item.max_cell_voltage >= cfg.lowest_gate) begin
        enable_nxt = 1'b1;
      end
      if (enable_nxt && spread <= $signed({{(VOLT_W-DIFF_W+1){1'b0}}, lo})) begin
        enable_nxt = 1'b0;
      end
      // debounced overrides
      if (item.min_cell_voltage > ALL_ON_LEVEL) begin
        on_cnt_nxt = on_cnt_r + 1'b1;
        if (on_cnt_nxt > cfg.count_limit) begin
          enable_nxt = 1'b1;
          on_cnt_nxt = '0;
        end
      end else begin
        on_cnt_nxt = '0;
      end
      if (item.max_cell_voltage < ALL_OFF_LEVEL || item.cells_saturated) begin
        off_cnt_nxt = off_cnt_r + 1'b1;
        if (off_cnt_nxt > cfg.count_limit) begin
          enable_nxt  = 1'b0;
          off_cnt_nxt = '0;
        end
      end else begin
        off_cnt_nxt = '0;
      end
      mask_nxt = enable_nxt ? (above_r & VALID_MASK) : '0;
    end
  end

  assign result.balance_enable = enable_nxt;
  assign result.cell_mask      = mask_nxt;
  assign result.tight_mode     = tight_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      tight_r     <= 1'b0;
      tight_cnt_r <= '0;
      on_cnt_r    <= '0;
      off_cnt_r   <= '0;
      above_r     <= '0;
      mask_r      <= '0;
    end else if (fire) begin
      enable_r    <= enable_nxt;
      tight_r     <= tight_nxt;
      tight_cnt_r <= tight_cnt_nxt;
      on_cnt_r    <= on_cnt_nxt;
      off_cnt_r   <= off_cnt_nxt;
      above_r     <= above_nxt;
      mask_r      <= mask_nxt;
    end
  end

endmodule

// ===== rtl/cell_balance_decision.sv =====
// Channel | Direction | Carries
// --------+-----------+------------------------------------------------------
// in_ch   | sink      | one request: cell sample or balancing evaluation
// out_ch  | source    | one result per request: enable, cell mask, tight mode
// APB     | slave     | eight threshold and debounce registers at 4*index
//
// Each request is held in the input register, then passes through the decision
// logic into the result register, which drives the output channel.
// A new request is taken every cycle while the result side keeps draining;
// with both registers full, input ready follows output ready in the same cycle.
// Reset (rst_n low, synchronous) clears all decision state and restores the
// register defaults. A stalled result holds and stalls the input register.
module cell_balance_decision #(
  parameter int NUM_CELLS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cbd_in_if.sink                         in_ch,
  cbd_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import cbd_pkg::*;

  localparam logic [CELL_W-1:0] VALID_MASK =
    (NUM_CELLS >= CELL_W) ? {CELL_W{1'b1}} : CELL_W'((32'd1 << NUM_CELLS) - 32'd1);

  cfg_t    cfg;
  item_t   item_r, item_in;
  result_t res, res_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  logic    advance;
  logic    fire;

  assign pready = 1'b1;

  cbd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Advance the result register whenever it is empty or being drained.
  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  assign item_in.req_type         = req_t'(in_ch.req_type);
  assign item_in.cell_index       = in_ch.cell_index;
  assign item_in.cell_voltage     = in_ch.cell_voltage;
  assign item_in.max_cell_voltage = in_ch.max_cell_voltage;
  assign item_in.min_cell_voltage = in_ch.min_cell_voltage;
  assign item_in.comm_force_off   = in_ch.comm_force_off;
  assign item_in.comm_force_on    = in_ch.comm_force_on;
  assign item_in.hardware_fault   = in_ch.hardware_fault;
  assign item_in.balance_allowed  = in_ch.balance_allowed;
  assign item_in.cells_saturated  = in_ch.cells_saturated;

  // Decision state lives in the core and commits only when the result loads.
  cbd_core #(
    .NUM_CELLS (NUM_CELLS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= item_in;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.balance_enable = res_r.balance_enable;
  assign out_ch.cell_mask      = res_r.cell_mask;
  assign out_ch.tight_mode     = res_r.tight_mode;

`ifndef NO_ASSERTIONS
  a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.cell_mask & ~VALID_MASK) == '0))
    else $error("cell mask has bits beyond the configured cell count");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(item_r)))
    else $error("input register lost a request while the result stalled");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a pending request");
`endif

endmodule
